### rtl/fnip_pkg.sv
// shared types and constants for the float to normalized integer packer
// no dependencies
package fnip_pkg;

    localparam logic       FUNC_SNORM8   = 1'b0;
    localparam logic       FUNC_UNORM16  = 1'b1;

    localparam logic [15:0] SNORM8_SCALE  = 16'd127;
    localparam logic [15:0] UNORM16_SCALE = 16'd65535;
    localparam logic [15:0] SNORM8_MAX    = 16'd127;
    localparam logic [15:0] UNORM16_MAX   = 16'd65535;

    // biased exponent of 1.0, and the exponent below which every code is zero
    localparam logic [7:0]  EXP_ONE       = 8'd127;
    localparam logic [7:0]  EXP_MIN_NZ    = 8'd100;
    localparam logic [7:0]  EXP_SPECIAL   = 8'hFF;

    typedef struct packed {
        logic        func;
        logic [31:0] value_bits;
    } t_in_item;

    typedef struct packed {
        logic [15:0] packed_res;
        logic        nan_input;
    } t_res_item;

endpackage

### rtl/float_to_normalized_int_pack.sv
// float to snorm8 / unorm16 conversion, one item per cycle
// depends on fnip_pkg
//
// a start transfer passes the input register, then the result register, which drives o_valid
// throughput: one item per clock, busy is never raised
// reset: synchronous active-low i_rst_n clears both valid flags, payload registers keep data
// the receiver cannot stall: every result is shown for exactly one cycle
module float_to_normalized_int_pack
    import fnip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_in,
    output logic      o_valid,
    output t_res_item o_res
);

    t_in_item  r_in;
    logic      r_in_vld;
    t_res_item r_res;
    t_res_item n_res;
    logic      r_res_vld;

    // field split of the registered float
    logic        w_sign;
    logic [7:0]  w_exp;
    logic [22:0] w_frac;
    logic        w_is_nan;
    logic        w_unorm;

    // exact product of the significand and the scale
    logic [23:0] w_mant;
    logic [15:0] w_scale;
    logic [39:0] w_prod_full;

    // single-precision rounding of the product
    logic [5:0]  w_rsh;
    logic [39:0] w_lo_mask;
    logic [39:0] w_half;
    logic [39:0] w_rem;
    logic        w_lsb;
    logic        w_up;
    logic [40:0] w_prod_rnd;

    // fixed point with 25 fraction bits
    logic [7:0]  w_exp_gap;
    logic [41:0] w_prod_fix;
    logic [41:0] w_sum;
    logic [5:0]  w_lead;
    logic [41:0] w_half_ulp;
    logic [41:0] w_round;
    logic [15:0] w_mag;
    logic [7:0]  w_mag8;

    assign busy = 1'b0;

    assign w_sign   = r_in.value_bits[31];
    assign w_exp    = r_in.value_bits[30:23];
    assign w_frac   = r_in.value_bits[22:0];
    assign w_is_nan = (w_exp == EXP_SPECIAL) && (w_frac != 23'd0);
    assign w_unorm  = (r_in.func == FUNC_UNORM16);

    // only normal inputs reach the arithmetic path, smaller ones give zero
    assign w_mant      = {1'b1, w_frac};
    assign w_scale     = w_unorm ? UNORM16_SCALE : SNORM8_SCALE;
    assign w_prod_full = {16'd0, w_mant} * {24'd0, w_scale};

    // product top bit sits at one of two places for each scale
    always_comb begin
        if (w_unorm) begin
            w_rsh = w_prod_full[39] ? 6'd16 : 6'd15;
        end else begin
            w_rsh = w_prod_full[30] ? 6'd7 : 6'd6;
        end
    end

    // round to 24 significant bits, ties to even
    assign w_lo_mask  = (40'd1 << w_rsh) - 40'd1;
    assign w_half     = 40'd1 << (w_rsh - 6'd1);
    assign w_rem      = w_prod_full & w_lo_mask;
    assign w_lsb      = w_prod_full[w_rsh];
    assign w_up       = (w_rem > w_half) || ((w_rem == w_half) && w_lsb);
    assign w_prod_rnd = {1'b0, w_prod_full & ~w_lo_mask}
                      + (w_up ? (41'd1 << w_rsh) : 41'd0);

    // align to 2^-25 resolution, dropped bits cannot move the final floor
    assign w_exp_gap  = EXP_ONE - 8'd1 - w_exp;
    assign w_prod_fix = {w_prod_rnd, 1'b0} >> w_exp_gap[4:0];
    assign w_sum      = w_prod_fix + (42'd1 << 24);

    // binade of the sum sets its half ulp
    always_comb begin
        w_lead = 6'd24;
        for (int i = 24; i <= 40; i++) begin
            if (w_sum[i]) begin
                w_lead = 6'(i);
            end
        end
    end

    // rounding the sum then flooring equals flooring sum plus half ulp, ties up
    assign w_half_ulp = 42'd1 << (w_lead - 6'd24);
    assign w_round    = w_sum + w_half_ulp;
    assign w_mag      = w_round[40:25];

    always_comb begin
        if (w_exp >= EXP_ONE) begin
            w_mag8 = SNORM8_MAX[7:0];
        end else if (w_exp < EXP_MIN_NZ) begin
            w_mag8 = 8'd0;
        end else begin
            w_mag8 = w_mag[7:0];
        end
    end

    always_comb begin
        n_res.nan_input  = 1'b0;
        n_res.packed_res = 16'd0;
        if (w_is_nan) begin
            n_res.nan_input = 1'b1;
        end else if (w_unorm) begin
            if (w_sign || (w_exp < EXP_MIN_NZ)) begin
                n_res.packed_res = 16'd0;
            end else if (w_exp >= EXP_ONE) begin
                n_res.packed_res = UNORM16_MAX;
            end else begin
                n_res.packed_res = w_mag;
            end
        end else begin
            // symmetric rounding, so negate the magnitude
            n_res.packed_res = {8'd0, w_sign ? (8'd0 - w_mag8) : w_mag8};
        end
    end

    // input register, a transfer every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        if (start && !busy) begin
            r_in <= i_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_in_vld;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_res_vld;
    assign o_res   = r_res;

endmodule

### rtl/fnip_checker.sv
// port-level checks for float_to_normalized_int_pack, bound into every instance of it
// depends on fnip_pkg
module fnip_checker
    import fnip_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_in,
    input logic      o_valid,
    input t_res_item o_res
);

    logic w_in_nan;
    assign w_in_nan = (i_in.value_bits[30:23] == EXP_SPECIAL)
                   && (i_in.value_bits[22:0] != 23'd0);

    // every result traces back to an earlier transfer through the input and result registers
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without a transfer");

    // every transfer yields a result after the input and result registers
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result lost");

    a_nan_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && w_in_nan) |-> ##2 (o_res.nan_input && o_res.packed_res == 16'd0))
        else $error("nan input not flagged");

    a_snorm_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.func == FUNC_SNORM8) |-> ##2 (o_res.packed_res[15:8] == 8'd0))
        else $error("snorm8 upper byte not zero");

endmodule

bind float_to_normalized_int_pack fnip_checker u_fnip_checker (.*);

### dv/tb_float_to_normalized_int_pack.sv
// self-checking testbench for float_to_normalized_int_pack (snorm8 / unorm16 packing)
// depends on fnip_pkg and the block itself; computes expected codes with exact integer math
`timescale 1ns / 100ps

module tb_float_to_normalized_int_pack;
    import fnip_pkg::*;

    // fixed point used by the predictor: value = X / 2^160, wide enough for the
    // smallest denormal times the scale and for the largest clamped product
    localparam int FRAC_BITS = 160;
    localparam int N_RANDOM  = 880;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_in;
    logic      o_valid;
    t_res_item o_res;

    t_in_item  pending_values[$];   // items still to be offered to the block
    t_res_item code_expect[$];      // expected results in transfer order

    int  n_fail    = 0;
    int  n_sent    = 0;
    int  n_checked = 0;
    int  n_nan     = 0;
    int  idle_pct  = 0;
    bit  stim_done;

    float_to_normalized_int_pack dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_in   (i_in),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    // clock; the single reset at the start comes from the reset sequence below
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // round a positive fixed-point value to 24 significant bits, ties to even
    function automatic logic [199:0] round_sig24(input logic [199:0] x);
        int             msb;
        int             sh;
        logic [199:0]   keep;
        logic [199:0]   rest;
        logic [199:0]   half;
        msb = -1;
        for (int i = 0; i < 200; i++) begin
            if (x[i]) msb = i;
        end
        if (msb <= 23) return x;
        sh   = msb - 23;
        keep = x >> sh;
        rest = x & ((200'd1 << sh) - 200'd1);
        half = 200'd1 << (sh - 1);
        if (rest > half || (rest == half && keep[0])) keep = keep + 200'd1;
        return keep << sh;
    endfunction

    // expected result for one input, single-precision multiply then add, both rounded
    function automatic t_res_item float_to_code(input t_in_item item);
        t_res_item      r;
        logic           sgn;
        logic [7:0]     ex;
        logic [22:0]    frac;
        logic [199:0]   mag;
        logic [199:0]   prod;
        logic [199:0]   total;
        logic [15:0]    q;
        logic [15:0]    scale;
        sgn  = item.value_bits[31];
        ex   = item.value_bits[30:23];
        frac = item.value_bits[22:0];
        r    = '0;
        // any nan: flag it, code zero
        if (ex == EXP_SPECIAL && frac != 0) begin
            r.nan_input = 1'b1;
            return r;
        end
        // magnitude in fixed point; values of 1 and above are clamped in each mode below
        if (ex == 8'd0) mag = 200'(frac) << (FRAC_BITS - 149);
        else            mag = 200'({1'b1, frac}) << (int'(ex) + FRAC_BITS - 150);
        if (item.func == FUNC_SNORM8) begin
            // out of range saturates at +-1, which packs to +-127
            if (ex >= EXP_ONE) q = SNORM8_MAX;
            else begin
                scale = SNORM8_SCALE;
                prod  = round_sig24(mag * 200'(scale));
                total = round_sig24(prod + (200'd1 << (FRAC_BITS - 1)));
                q     = 16'(total >> FRAC_BITS);
            end
            // negative side is symmetric: subtract half, truncate toward zero
            if (sgn) q = 16'(-q);
            r.packed_res = {8'h00, q[7:0]};
        end else begin
            // negatives, including negative zero, clamp to zero
            if (sgn) q = 16'd0;
            else if (ex >= EXP_ONE) q = UNORM16_MAX;
            else begin
                scale = UNORM16_SCALE;
                prod  = round_sig24(mag * 200'(scale));
                total = round_sig24(prod + (200'd1 << (FRAC_BITS - 1)));
                q     = 16'(total >> FRAC_BITS);
            end
            r.packed_res = q;
        end
        return r;
    endfunction

    // stimulus: directed corners in both modes, then random items
    initial begin
        logic [31:0] corners[12];
        t_in_item    it;
        int          kind;
        corners = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                    32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
                    32'h0000_0001, 32'h807F_FFFF, 32'h3F7F_FFFF, 32'h7F7F_FFFF};
        foreach (corners[k]) begin
            it.func = FUNC_SNORM8;  it.value_bits = corners[k]; pending_values.push_back(it);
            it.func = FUNC_UNORM16; it.value_bits = corners[k]; pending_values.push_back(it);
        end
        // snorm8 half-code tie point: 0.5/127
        it.func = FUNC_SNORM8;  it.value_bits = 32'h3B81_0204; pending_values.push_back(it);
        for (int n = 0; n < N_RANDOM; n++) begin
            it.func = ($urandom_range(0, 1) == 1) ? FUNC_UNORM16 : FUNC_SNORM8;
            kind    = $urandom_range(0, 9);
            if (kind < 3) begin
                // any bit pattern: nan, inf, huge and tiny values
                it.value_bits = $urandom;
            end else if (kind < 9) begin
                // mostly the interesting range, roughly 7e-9 to just below 2
                it.value_bits = {1'($urandom), 8'($urandom_range(int'(EXP_MIN_NZ), 127)),
                                 23'($urandom)};
            end else begin
                it.value_bits = {1'($urandom), 8'd0, 23'($urandom)};
            end
            pending_values.push_back(it);
        end
        stim_done = 1'b1;
    end

    // reset sequence
    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: offers the next item at each edge unless it chooses to idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_in  <= '0;
        end else begin
            // a transfer happens on this edge: record what it must produce
            if (start && !busy) begin
                code_expect.push_back(float_to_code(i_in));
                n_sent++;
            end
            // idling phases by progress: none, sender idle 46 percent, none, 26 percent
            case ((n_sent / 120) % 4)
                0: idle_pct = 0;
                1: idle_pct = 46;
                2: idle_pct = 0;
                default: idle_pct = 26;
            endcase
            if (start && busy) begin
                // hold the item until it is taken
            end else if (pending_values.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                start <= 1'b1;
                i_in  <= pending_values.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: each strobe is one result transfer
    always @(posedge i_clk) begin
        t_res_item want;
        if (i_rst_n && o_valid) begin
            if (code_expect.size() == 0) begin
                $display("%0t: unexpected result packed=%h nan=%b",
                         $time, o_res.packed_res, o_res.nan_input);
                n_fail++;
            end else begin
                want = code_expect.pop_front();
                if (o_res.packed_res !== want.packed_res) begin
                    $display("%0t: packed_res mismatch expected %h actual %h",
                             $time, want.packed_res, o_res.packed_res);
                    n_fail++;
                end
                if (o_res.nan_input !== want.nan_input) begin
                    $display("%0t: nan_input mismatch expected %b actual %b",
                             $time, want.nan_input, o_res.nan_input);
                    n_fail++;
                end
                if (want.nan_input) n_nan++;
                n_checked++;
            end
        end
    end

    // end of run: all items taken, all results seen, then a short drain
    initial begin
        wait (stim_done && pending_values.size() == 0);
        @(posedge i_clk);
        wait (!start);
        wait (code_expect.size() == 0);
        repeat (8) @(posedge i_clk);
        $display("checked %0d conversions (%0d nan) across snorm8 and unorm16 modes",
                 n_checked, n_nan);
        if (n_fail == 0 && code_expect.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", code_expect.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
